FILE: rtl/core/pck_pkg.sv
// Shared types and constants for the p-persistent CSMA transmit keyer.
package pck_pkg;

    // Channel payloads
    typedef struct packed {
        logic [2:0] cmd;
        logic       carrier_busy;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        ptt_on;
        logic        audio_enable;
        logic [31:0] count_requests;
        logic [31:0] count_grants;
        logic [31:0] count_busy_denials;
        logic [31:0] count_deferrals;
        logic [31:0] count_timeouts;
        logic [31:0] count_aborts;
        logic [31:0] count_key_ups;
        logic [31:0] count_key_downs;
    } t_out;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg_wr;

    // Settings as the keyer core sees them, already in ticks
    typedef struct packed {
        logic [7:0]  persistence;
        logic [7:0]  slot_time;
        logic        full_duplex;
        logic [12:0] delay_ticks;
        logic [12:0] tail_ticks;
        logic [16:0] max_ticks;
        logic        seed_load;
        logic [31:0] seed;
    } t_cfg;

    // Commands
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_REQUEST = 3'd1;
    localparam logic [2:0] CMD_DONE    = 3'd2;
    localparam logic [2:0] CMD_ABORT   = 3'd3;
    localparam logic [2:0] CMD_CARRIER = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_DENIED  = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // Register indexes
    localparam logic [2:0] CFG_PERSIST = 3'd0;
    localparam logic [2:0] CFG_SLOT    = 3'd1;
    localparam logic [2:0] CFG_DUPLEX  = 3'd2;
    localparam logic [2:0] CFG_DELAY   = 3'd3;
    localparam logic [2:0] CFG_TAIL    = 3'd4;
    localparam logic [2:0] CFG_MAX_TX  = 3'd5;
    localparam logic [2:0] CFG_SEED    = 3'd6;

    // Phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_WAIT   = 3'd1;
    localparam logic [2:0] PH_DELAY  = 3'd2;
    localparam logic [2:0] PH_ACTIVE = 3'd3;
    localparam logic [2:0] PH_TAIL   = 3'd4;

    // Statistics counter slots
    localparam int unsigned CNT_REQ     = 0;
    localparam int unsigned CNT_GRANT   = 1;
    localparam int unsigned CNT_BUSYDEN = 2;
    localparam int unsigned CNT_DEFER   = 3;
    localparam int unsigned CNT_TIMEOUT = 4;
    localparam int unsigned CNT_ABORT   = 5;
    localparam int unsigned CNT_KEYUP   = 6;
    localparam int unsigned CNT_KEYDN   = 7;
    localparam int unsigned NUM_CNT     = 8;

    // LCG
    localparam logic [31:0] RNG_MUL = 32'd1103515245;
    localparam logic [31:0] RNG_INC = 32'd12345;
    // state 1 advanced once: the value drawn first after reset
    localparam logic [31:0] RNG_DRAW_RST = 32'h41C6_7EA6;

    // ms -> ticks: (ms + 9) / 10 as (x * RECIP) >> SHIFT, exact for x < 2^22
    localparam logic [20:0] MS_ROUND    = 21'd9;
    localparam logic [20:0] TICK_RECIP  = 21'd838861;
    localparam int unsigned TICK_SHIFT  = 23;

    // Reset settings
    localparam logic [7:0]  PERSIST_RST    = 8'd255;
    localparam logic [7:0]  SLOT_RST       = 8'd10;
    localparam logic [7:0]  PERSIST_ALWAYS = 8'd255;
    localparam logic [16:0] MAX_TICKS_DEF  = 17'd3000;

endpackage

FILE: rtl/core/pck_if.sv
// Valid/ready channel interfaces for keyer requests, results and register writes.
interface pck_in_if;
    logic         valid;
    logic         ready;
    pck_pkg::t_in payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pck_out_if;
    logic          valid;
    logic          ready;
    pck_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pck_cfg_if;
    logic             valid;
    logic             ready;
    pck_pkg::t_cfg_wr payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/pck_cfg.sv
// Configuration registers with millisecond to tick conversion on write.
module pck_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pck_cfg_if.sink       i_cfg,
    output pck_pkg::t_cfg o_cfg
);

    logic [7:0]  r_persist;
    logic [7:0]  r_slot_time;
    logic        r_duplex;
    logic [12:0] r_delay_ticks;
    logic [12:0] r_tail_ticks;
    logic [16:0] r_max_ticks;

    logic [2:0]  wr_index;
    logic [31:0] wr_data;
    logic [19:0] ms_src;
    logic [20:0] ms_x;
    logic [41:0] prod;
    logic [17:0] ticks;

    assign i_cfg.ready = 1'b1;
    assign wr_index    = i_cfg.payload.index;
    assign wr_data     = i_cfg.payload.data;

    // one shared converter; only the timeout field is 20 bits wide
    assign ms_src = (wr_index == pck_pkg::CFG_MAX_TX) ? wr_data[19:0]
                                                       : {4'b0, wr_data[15:0]};
    assign ms_x   = {1'b0, ms_src} + pck_pkg::MS_ROUND;
    assign prod   = 42'(ms_x) * 42'(pck_pkg::TICK_RECIP);
    assign ticks  = prod[pck_pkg::TICK_SHIFT +: 18];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persist     <= pck_pkg::PERSIST_RST;
            r_slot_time   <= pck_pkg::SLOT_RST;
            r_duplex      <= 1'b0;
            r_delay_ticks <= '0;
            r_tail_ticks  <= '0;
            r_max_ticks   <= pck_pkg::MAX_TICKS_DEF;
        end else if (i_cfg.valid) begin
            unique case (wr_index)
                pck_pkg::CFG_PERSIST: r_persist     <= wr_data[7:0];
                pck_pkg::CFG_SLOT:    r_slot_time   <= wr_data[7:0];
                pck_pkg::CFG_DUPLEX:  r_duplex      <= wr_data[0];
                pck_pkg::CFG_DELAY:   r_delay_ticks <= ticks[12:0];
                pck_pkg::CFG_TAIL:    r_tail_ticks  <= ticks[12:0];
                pck_pkg::CFG_MAX_TX: begin
                    r_max_ticks <= (ms_src == 20'd0) ? pck_pkg::MAX_TICKS_DEF : ticks[16:0];
                end
                default: ;
            endcase
        end
    end

    assign o_cfg.persistence = r_persist;
    assign o_cfg.slot_time   = r_slot_time;
    assign o_cfg.full_duplex = r_duplex;
    assign o_cfg.delay_ticks = r_delay_ticks;
    assign o_cfg.tail_ticks  = r_tail_ticks;
    assign o_cfg.max_ticks   = r_max_ticks;
    assign o_cfg.seed_load   = i_cfg.valid && (wr_index == pck_pkg::CFG_SEED);
    assign o_cfg.seed        = (wr_data == 32'd0) ? 32'd1 : wr_data;

endmodule

FILE: rtl/core/pck_core.sv
// Keyer state update, random draw, statistics counters and result register.
module pck_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_item_vld,
    input  pck_pkg::t_in  i_item,
    output logic          o_item_take,
    input  pck_pkg::t_cfg i_cfg,
    output logic          o_out_vld,
    output pck_pkg::t_out o_out,
    input  logic          i_out_rdy
);

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_slot, n_slot;
    logic [12:0] r_delay, n_delay;
    logic [12:0] r_tail, n_tail;
    logic [16:0] r_tmo, n_tmo;
    logic        r_carrier, n_carrier;
    logic        r_ptt, n_ptt;
    logic [31:0] r_draw, n_draw;
    logic [31:0] r_cnt [pck_pkg::NUM_CNT];
    logic [31:0] n_cnt [pck_pkg::NUM_CNT];
    logic        r_out_vld;
    pck_pkg::t_out r_out, n_out;

    logic [1:0]  status;
    logic [7:0]  inc;
    logic        try_grant;
    logic        raise;
    logic        drop;
    logic        g_busy, g_defer, g_draw;
    logic [7:0]  rnd_byte;
    logic [7:0]  slot_reload;
    logic [31:0] rng_src;

    assign o_item_take = i_item_vld && (!r_out_vld || i_out_rdy);
    assign rnd_byte    = r_draw[23:16];
    assign slot_reload = (i_cfg.slot_time == 8'd0) ? 8'd1 : i_cfg.slot_time;

    // grant outcome, valid whenever a grant is tried this cycle
    assign g_busy  = !i_cfg.full_duplex && r_carrier;
    assign g_defer = !g_busy && ((i_cfg.persistence == 8'd0) ||
                     (i_cfg.persistence != pck_pkg::PERSIST_ALWAYS &&
                      rnd_byte >= i_cfg.persistence));
    assign g_draw  = !g_busy && (i_cfg.persistence != 8'd0) &&
                     (i_cfg.persistence != pck_pkg::PERSIST_ALWAYS);

    always_comb begin
        n_phase   = r_phase;
        n_slot    = r_slot;
        n_delay   = r_delay;
        n_tail    = r_tail;
        n_tmo     = r_tmo;
        n_carrier = r_carrier;
        n_ptt     = r_ptt;
        status    = pck_pkg::ST_OK;
        inc       = '0;
        try_grant = 1'b0;
        raise     = 1'b0;
        drop      = 1'b0;

        case (i_item.cmd)
            pck_pkg::CMD_TICK: begin
                if (r_phase == pck_pkg::PH_WAIT) begin
                    n_slot = (r_slot != 8'd0) ? r_slot - 8'd1 : r_slot;
                    if (n_slot == 8'd0) begin
                        try_grant = 1'b1;
                    end
                end else if (r_phase == pck_pkg::PH_DELAY || r_phase == pck_pkg::PH_ACTIVE ||
                             r_phase == pck_pkg::PH_TAIL) begin
                    n_tmo = (r_tmo != 17'd0) ? r_tmo - 17'd1 : r_tmo;
                    if (n_tmo == 17'd0) begin
                        inc[pck_pkg::CNT_TIMEOUT] = 1'b1;
                        n_phase = pck_pkg::PH_IDLE;
                        n_slot  = '0;
                        n_delay = '0;
                        n_tail  = '0;
                        drop    = 1'b1;
                        status  = pck_pkg::ST_TIMEOUT;
                    end else if (r_phase == pck_pkg::PH_DELAY) begin
                        n_delay = (r_delay != 13'd0) ? r_delay - 13'd1 : r_delay;
                        if (n_delay == 13'd0) begin
                            n_phase = pck_pkg::PH_ACTIVE;
                        end
                    end else if (r_phase == pck_pkg::PH_TAIL) begin
                        n_tail = (r_tail != 13'd0) ? r_tail - 13'd1 : r_tail;
                        if (n_tail == 13'd0) begin
                            n_phase = pck_pkg::PH_IDLE;
                            n_tmo   = '0;
                            drop    = 1'b1;
                        end
                    end
                end
            end
            pck_pkg::CMD_REQUEST: begin
                if (r_phase != pck_pkg::PH_IDLE) begin
                    status = pck_pkg::ST_BUSY;
                end else begin
                    inc[pck_pkg::CNT_REQ] = 1'b1;
                    try_grant = 1'b1;
                end
            end
            pck_pkg::CMD_DONE: begin
                if (r_phase != pck_pkg::PH_ACTIVE) begin
                    status = pck_pkg::ST_DENIED;
                end else begin
                    n_tail = i_cfg.tail_ticks;
                    if (i_cfg.tail_ticks == 13'd0) begin
                        n_phase = pck_pkg::PH_IDLE;
                        n_tmo   = '0;
                        drop    = 1'b1;
                    end else begin
                        n_phase = pck_pkg::PH_TAIL;
                    end
                end
            end
            pck_pkg::CMD_ABORT: begin
                inc[pck_pkg::CNT_ABORT] = 1'b1;
                n_phase = pck_pkg::PH_IDLE;
                n_slot  = '0;
                n_delay = '0;
                n_tail  = '0;
                n_tmo   = '0;
                drop    = 1'b1;
            end
            pck_pkg::CMD_CARRIER: begin
                n_carrier = i_item.carrier_busy;
            end
            default: ;
        endcase

        if (try_grant) begin
            if (g_busy) begin
                inc[pck_pkg::CNT_BUSYDEN] = 1'b1;
            end else if (g_defer) begin
                inc[pck_pkg::CNT_DEFER] = 1'b1;
            end else begin
                inc[pck_pkg::CNT_GRANT] = 1'b1;
                n_tmo   = i_cfg.max_ticks;
                n_delay = i_cfg.delay_ticks;
                n_phase = (i_cfg.delay_ticks == 13'd0) ? pck_pkg::PH_ACTIVE
                                                       : pck_pkg::PH_DELAY;
                raise   = 1'b1;
            end
            // refused from idle or from a slot expiry: wait another slot
            if (g_busy || g_defer) begin
                status  = pck_pkg::ST_DENIED;
                n_phase = pck_pkg::PH_WAIT;
                n_slot  = slot_reload;
            end
        end

        if (raise && !r_ptt) begin
            n_ptt = 1'b1;
            inc[pck_pkg::CNT_KEYUP] = 1'b1;
        end
        if (drop && r_ptt) begin
            n_ptt = 1'b0;
            inc[pck_pkg::CNT_KEYDN] = 1'b1;
        end

        for (int i = 0; i < pck_pkg::NUM_CNT; i++) begin
            n_cnt[i] = r_cnt[i] + {31'b0, inc[i]};
        end

        n_out.status             = status;
        n_out.ptt_on             = n_ptt;
        n_out.audio_enable       = (n_phase == pck_pkg::PH_ACTIVE);
        n_out.count_requests     = n_cnt[pck_pkg::CNT_REQ];
        n_out.count_grants       = n_cnt[pck_pkg::CNT_GRANT];
        n_out.count_busy_denials = n_cnt[pck_pkg::CNT_BUSYDEN];
        n_out.count_deferrals    = n_cnt[pck_pkg::CNT_DEFER];
        n_out.count_timeouts     = n_cnt[pck_pkg::CNT_TIMEOUT];
        n_out.count_aborts       = n_cnt[pck_pkg::CNT_ABORT];
        n_out.count_key_ups      = n_cnt[pck_pkg::CNT_KEYUP];
        n_out.count_key_downs    = n_cnt[pck_pkg::CNT_KEYDN];
    end

    // r_draw already holds the advanced LCG state, so a draw is just a register read
    assign rng_src = i_cfg.seed_load ? i_cfg.seed : r_draw;
    assign n_draw  = rng_src * pck_pkg::RNG_MUL + pck_pkg::RNG_INC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= pck_pkg::PH_IDLE;
            r_slot    <= '0;
            r_delay   <= '0;
            r_tail    <= '0;
            r_tmo     <= '0;
            r_carrier <= 1'b0;
            r_ptt     <= 1'b0;
            r_draw    <= pck_pkg::RNG_DRAW_RST;
            r_out_vld <= 1'b0;
            for (int i = 0; i < pck_pkg::NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_cfg.seed_load || (o_item_take && try_grant && g_draw)) begin
                r_draw <= n_draw;
            end
            if (o_item_take) begin
                r_phase   <= n_phase;
                r_slot    <= n_slot;
                r_delay   <= n_delay;
                r_tail    <= n_tail;
                r_tmo     <= n_tmo;
                r_carrier <= n_carrier;
                r_ptt     <= n_ptt;
                r_out_vld <= 1'b1;
                for (int i = 0; i < pck_pkg::NUM_CNT; i++) begin
                    r_cnt[i] <= n_cnt[i];
                end
            end else if (i_out_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_vld = r_out_vld;
    assign o_out     = r_out;

endmodule

FILE: rtl/core/p_persistent_csma_tx_keyer_top.sv
// Top level of the p-persistent CSMA transmit keyer.
// One event request enters per clock while the request register can take it, and each one
// gives exactly one result: a request register, then a combinational state update that
// loads the result register. Throughput is one request per cycle while the result side keeps
// up; the request channel stalls only when both the request and result registers are full.
// Register writes are always taken and apply from the next cycle; millisecond settings are
// converted to 10 ms ticks at write time, and a seed write reloads the random generator.
module p_persistent_csma_tx_keyer_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pck_in_if.sink   i_in,
    pck_out_if.source o_out,
    pck_cfg_if.sink  i_cfg
);

    logic          r_in_vld;
    pck_pkg::t_in  r_in;
    logic          item_take;
    pck_pkg::t_cfg cfg;
    logic          out_vld;
    pck_pkg::t_out out_data;

    assign i_in.ready = !r_in_vld || item_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
    end

    pck_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pck_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_vld  (r_in_vld),
        .i_item      (r_in),
        .o_item_take (item_take),
        .i_cfg       (cfg),
        .o_out_vld   (out_vld),
        .o_out       (out_data),
        .i_out_rdy   (o_out.ready)
    );

    assign o_out.valid   = out_vld;
    assign o_out.payload = out_data;

endmodule

FILE: rtl/core/pck_checker.sv
// Port-level assertions for the keyer top, attached by bind.
module pck_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input pck_pkg::t_out i_out_payload
);

    // no result may be pending right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("stalled result changed");

    // audio only flows with the transmitter keyed
    a_audio_keyed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.audio_enable |-> i_out_payload.ptt_on)
        else $error("audio enabled with PTT off");

    a_timeout_unkeys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_payload.status == pck_pkg::ST_TIMEOUT)
            |-> !i_out_payload.ptt_on && !i_out_payload.audio_enable)
        else $error("timeout left transmitter keyed");

    // key-up and key-down counts differ exactly by the PTT level
    a_key_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_out_payload.count_key_ups - i_out_payload.count_key_downs)
                         == {31'b0, i_out_payload.ptt_on}))
        else $error("key-up/key-down counts out of balance");

endmodule

bind p_persistent_csma_tx_keyer_top pck_checker u_pck_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
